### sv/sidasc_pkg.sv
package sidasc_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * DEC_DIGITS;
  localparam int IDX_W      = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

### sv/sidasc_bcd.sv
module sidasc_bcd
  import sidasc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VALUE_W-1:0]  mag,
  output logic                done,
  output logic [BCD_W-1:0]    bcd
);

  localparam int CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = bcd_r[DIGIT_W*i +: DIGIT_W];
      adj[DIGIT_W*i +: DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

### sv/signed_int_to_decimal_ascii_core.sv
// Converts a 32-bit two's-complement value to decimal ASCII, most significant
// character first: a leading '-' for negative values, no leading zeros, a single
// '0' for zero, and out_last_char set on the final character. The most negative
// value prints as "-2147483648" (eleven characters). Each request is accepted,
// its magnitude is shifted through the shift-and-add-3 (double-dabble) loop, the
// first digit is picked, and then one character per cycle goes out while
// out_ready is high. in_ready is high only between requests; a last character
// still waiting at the output does not hold off the next request.
module signed_int_to_decimal_ascii_core
  import sidasc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_text_char,
  output logic               out_last_char
);

  state_t             state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic               minus_r, minus_nxt;
  logic [IDX_W-1:0]   dig_r, dig_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [VALUE_W-1:0] raw, mag;
  logic [BCD_W-1:0]   bcd;
  logic [IDX_W-1:0]   lead;
  logic [DIGIT_W-1:0] digit_sel;
  logic               load;
  logic               bcd_start;
  logic               bcd_done;

  assign in_ready  = (state_r == ST_IDLE);
  assign bcd_start = in_valid && in_ready;
  assign raw       = in_value;
  assign mag       = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

  sidasc_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .mag   (mag),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  always_comb begin
    lead = '0;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      if (bcd[DIGIT_W*k +: DIGIT_W] != '0) lead = IDX_W'(k);
    end
  end

  assign digit_sel = bcd[{dig_r, 2'b00} +: DIGIT_W];
  assign load      = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    minus_nxt     = minus_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (bcd_start) begin
          neg_nxt   = raw[VALUE_W-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          dig_nxt   = lead;
          minus_nxt = neg_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (minus_r) begin
            out_char_nxt = ASCII_MINUS;
            out_last_nxt = 1'b0;
            minus_nxt    = 1'b0;
          end else begin
            out_char_nxt = ASCII_ZERO + {4'd0, digit_sel};
            out_last_nxt = (dig_r == '0);
            if (dig_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              dig_nxt = dig_r - 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    minus_r    <= minus_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

  a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (dig_r < IDX_W'(DEC_DIGITS)))
    else $error("digit pointer out of range");

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_done |-> (state_r == ST_CONV))
    else $error("conversion finished outside conversion state");

  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_start |=> (state_r == ST_CONV))
    else $error("accepted request did not start conversion");

  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |-> (out_text_char != ASCII_MINUS))
    else $error("minus sign flagged as last character");

endmodule

### verif/tb_signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_core;
  import sidasc_pkg::*;

  localparam int N_DIRECTED    = 21;
  localparam int RANDOM_VALUES = 380;
  localparam int PHASE_LEN     = 134;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 60;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } ascii_char_t;

  typedef struct {
    logic [31:0] value;
    string       text;
  } directed_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_text_char;
  logic               out_last_char;

  ascii_char_t expected_chars_q[$];
  ascii_char_t next_char;
  int          mismatch_count = 0;
  int          stall_cycles   = 0;
  int          send_idle_pct  = 18;
  int          recv_idle_pct  = 79;

  // an empty text means: take the expectation from the predictor
  directed_row_t directed_rows[N_DIRECTED] = '{
    '{32'd0,                "0"},
    '{32'd1,                "1"},
    '{32'hFFFF_FFFF,        "-1"},
    '{32'h7FFF_FFFF,        "2147483647"},
    '{32'h8000_0000,        "-2147483648"},
    '{32'h8000_0001,        ""},
    '{32'd9,                ""},
    '{32'd10,               ""},
    '{-32'sd9,              ""},
    '{-32'sd10,             ""},
    '{32'd99,               ""},
    '{32'd100,              ""},
    '{32'd999999999,        ""},
    '{32'd1000000000,       ""},
    '{-32'sd1000000000,     ""},
    '{32'd1000000009,       ""},
    '{32'h5555_5555,        ""},
    '{32'hAAAA_AAAA,        ""},
    '{32'd1234567890,       ""},
    '{-32'sd1234567890,     ""},
    '{32'd2147483646,       ""}
  };

  signed_int_to_decimal_ascii_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void queue_decimal_text(logic [31:0] value);
    logic        negative;
    logic [31:0] magnitude;
    logic [3:0]  digits[10];
    int          n_digits;
    negative  = value[31];
    magnitude = negative ? (32'd0 - value) : value;
    n_digits  = 0;
    do begin
      digits[n_digits] = 4'(magnitude % 32'd10);
      n_digits++;
      magnitude = magnitude / 32'd10;
    end while (magnitude != 0 && n_digits < 10);
    if (negative) begin
      expected_chars_q.push_back('{ASCII_MINUS, 1'b0});
    end
    for (int k = n_digits - 1; k >= 0; k--) begin
      expected_chars_q.push_back('{ASCII_ZERO + 8'(digits[k]), k == 0});
    end
  endfunction

  function automatic void queue_typed_text(string text);
    for (int k = 0; k < text.len(); k++) begin
      expected_chars_q.push_back('{8'(text[k]), k == text.len() - 1});
    end
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] value;
    int unsigned offset;
    offset = $urandom_range(15);
    case ($urandom_range(3))
      0: value = $urandom;
      1: value = $urandom_range(999);
      2: value = $urandom_range(1) ? 32'h8000_0000 + offset : 32'h7FFF_FFFF - offset;
      default: value = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) begin
      value = 32'd0 - value;
    end
    return value;
  endfunction

  task automatic send_request(input logic [31:0] value, input string typed_text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed_text.len() != 0) begin
      queue_typed_text(typed_text);
    end else begin
      queue_decimal_text(value);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars_q.size() == 0) begin
        $display("%0t: stray char, expected none, actual %h last %b",
                 $time, out_text_char, out_last_char);
        mismatch_count++;
      end else begin
        next_char = expected_chars_q.pop_front();
        if (out_text_char !== next_char.text_char) begin
          $display("%0t: text_char expected %h actual %h",
                   $time, next_char.text_char, out_text_char);
          mismatch_count++;
        end
        if (out_last_char !== next_char.last_char) begin
          $display("%0t: last_char expected %b actual %b",
                   $time, next_char.last_char, out_last_char);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no request or character accepted for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < N_DIRECTED + RANDOM_VALUES; k++) begin
      if (k == PHASE_LEN) begin
        send_idle_pct = 79;
        recv_idle_pct <= 18;
      end else if (k == 2 * PHASE_LEN) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (k < N_DIRECTED) begin
        send_request(directed_rows[k].value, directed_rows[k].text);
      end else begin
        send_request(random_value(), "");
      end
    end
    in_valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
